FILE: rtl/arctan_pade_approximant_defines.svh
// ----------------------------------------------------------------------------
// arctan_pade_approximant_defines.svh
// Assertion macros shared by the arctan Pade approximant RTL.
// ----------------------------------------------------------------------------
`ifndef ARCTAN_PADE_APPROXIMANT_DEFINES_SVH
`define ARCTAN_PADE_APPROXIMANT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ATANPA_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atanpa: implication check failed");

// Antecedent implies consequent a fixed number of cycles later.
`define ATANPA_ASSERT_DELAY(name, clk, rst_n, ante, n, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("atanpa: delayed check failed");

`endif

FILE: rtl/atanpa_pkg.sv
// ----------------------------------------------------------------------------
// atanpa_pkg
// Constants, coefficient tables and helpers for the arctan Pade pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atanpa_pkg;

    localparam int FRAC_BITS = 12;
    localparam int U_SHL     = (2 * FRAC_BITS <= 30) ? (30 - 2 * FRAC_BITS) : 0;
    localparam int U_SHR     = (2 * FRAC_BITS > 30) ? (2 * FRAC_BITS - 30) : 0;
    localparam int U_W       = 31 + U_SHL;   // x^2 in Q30
    localparam int V_W       = 31;           // Horner operand, <= 1.0 in Q30
    localparam int H_W       = 35;           // Horner accumulators, signed Q30
    localparam int QB        = 32;           // ratio quotient bits
    localparam int R_W       = 36;           // ratio and 1 + ratio, signed Q30
    localparam int HSTEPS    = 5;
    localparam int PIPE_LAT  = 1 + (V_W + 1) + 2 * HSTEPS + (QB + 1) + 2;

    localparam logic signed [H_W-1:0] QONE = 35'sd1073741824;

    typedef struct packed {
        logic              valid;
        logic              low_arg;
        logic signed [15:0] x;
    } tag_t;

    function automatic logic signed [H_W-1:0] num_coef(input int idx);
        logic signed [H_W-1:0] c;
        unique case (idx)
            0:       c = -35'sd357913941;
            1:       c = -35'sd722645291;
            2:       c = -35'sd479012643;
            3:       c = -35'sd115271793;
            4:       c = -35'sd7287006;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [H_W-1:0] den_coef(input int idx);
        logic signed [H_W-1:0] c;
        unique case (idx)
            0:       c = 35'sd2812180968;
            1:       c = 35'sd2664171443;
            2:       c = 35'sd1097011771;
            3:       c = 35'sd182835295;
            4:       c = 35'sd8438552;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Small argument runs Horner in x^2 from the top coefficient; large
    // argument runs in 1/x^2 from the bottom one.
    function automatic logic signed [H_W-1:0] p_addend(input logic low_arg, input int k);
        logic signed [H_W-1:0] c;
        if (low_arg)
            c = (k < 4) ? num_coef(3 - k) : '0;
        else
            c = num_coef(k);
        return c;
    endfunction

    function automatic logic signed [H_W-1:0] q_addend(input logic low_arg, input int k);
        logic signed [H_W-1:0] c;
        if (low_arg)
            c = (k < 4) ? den_coef(3 - k) : QONE;
        else
            c = den_coef(k);
        return c;
    endfunction

    function automatic logic [H_W-1:0] hmag(input logic signed [H_W-1:0] a);
        logic [H_W-1:0] m;
        m = a[H_W-1] ? H_W'(-a) : H_W'(a);
        return m;
    endfunction

endpackage

FILE: rtl/atanpa_recip.sv
// ----------------------------------------------------------------------------
// atanpa_recip
// Pipelined restoring divider for round(2^60 / u), one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atanpa_recip
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  atanpa_pkg::tag_t              in_tag,
    input  logic [atanpa_pkg::U_W-1:0]    u,
    output atanpa_pkg::tag_t              out_tag,
    output logic [atanpa_pkg::V_W-1:0]    w
);

    localparam int UW  = atanpa_pkg::U_W;
    localparam int VW  = atanpa_pkg::V_W;
    localparam int NST = VW;

    atanpa_pkg::tag_t tag_reg [0:NST];
    logic [UW-1:0]    u_reg   [0:NST];
    logic [UW-1:0]    rem_reg [0:NST];
    logic [VW-1:0]    quo_reg [0:NST];

    atanpa_pkg::tag_t tag_next;
    logic [UW-1:0]    rem_next;

    // Dividend is 2^60 + u/2; its top part (bits 60..31) seeds the remainder.
    always_comb
    begin
        tag_next         = in_tag;
        tag_next.low_arg = (64'(u) <= 64'd1073741824);
        rem_next         = UW'((64'(u) >> 32) + 64'd536870912);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg[0]   <= u;
        rem_reg[0] <= rem_next;
        quo_reg[0] <= '0;
    end

    for (genvar i = 0; i < NST; i++)
    begin : g_stage
        localparam int B = NST - 1 - i;
        logic [63:0] ue;
        logic [UW:0] trial;
        logic        ge;

        assign ue    = 64'(u_reg[i]);
        assign trial = {rem_reg[i], ue[B+1]};
        assign ge    = (trial >= {1'b0, u_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i+1] <= '0;
            end
            else
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            u_reg[i+1]   <= u_reg[i];
            rem_reg[i+1] <= ge ? UW'(trial - {1'b0, u_reg[i]}) : UW'(trial);
            quo_reg[i+1] <= {quo_reg[i][VW-2:0], ge};
        end
    end

    assign out_tag = tag_reg[NST];
    assign w       = tag_reg[NST].low_arg ? VW'(u_reg[NST]) : quo_reg[NST];

endmodule

FILE: rtl/atanpa_horner.sv
// ----------------------------------------------------------------------------
// atanpa_horner
// Five Horner steps for numerator and denominator, multiply then round/add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atanpa_horner
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  atanpa_pkg::tag_t                  in_tag,
    input  logic [atanpa_pkg::V_W-1:0]        w,
    output atanpa_pkg::tag_t                  out_tag,
    output logic signed [atanpa_pkg::H_W-1:0] p,
    output logic signed [atanpa_pkg::H_W-1:0] q
);

    localparam int VW   = atanpa_pkg::V_W;
    localparam int HW   = atanpa_pkg::H_W;
    localparam int NS   = atanpa_pkg::HSTEPS;
    localparam int PM_W = VW + HW;

    atanpa_pkg::tag_t       st_tag [0:NS-1];
    logic [VW-1:0]          st_w   [0:NS-1];
    logic signed [HW-1:0]   st_p   [0:NS-1];
    logic signed [HW-1:0]   st_q   [0:NS-1];

    atanpa_pkg::tag_t       tm_reg [0:NS-1];
    logic [VW-1:0]          wm_reg [0:NS-1];
    logic [PM_W-1:0]        mp_reg [0:NS-1];
    logic [PM_W-1:0]        mq_reg [0:NS-1];
    logic                   np_reg [0:NS-1];
    logic                   nq_reg [0:NS-1];

    atanpa_pkg::tag_t       ta_reg [0:NS-1];
    logic [VW-1:0]          wa_reg [0:NS-1];
    logic signed [HW-1:0]   p_reg  [0:NS-1];
    logic signed [HW-1:0]   q_reg  [0:NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        logic [PM_W-1:0]      rp;
        logic [PM_W-1:0]      rq;
        logic signed [HW-1:0] sp;
        logic signed [HW-1:0] sq;

        if (k == 0)
        begin : g_first
            assign st_tag[0] = in_tag;
            assign st_w[0]   = w;
            assign st_p[0]   = in_tag.low_arg ? atanpa_pkg::num_coef(4) : '0;
            assign st_q[0]   = in_tag.low_arg ? atanpa_pkg::den_coef(4) : atanpa_pkg::QONE;
        end
        else
        begin : g_next
            assign st_tag[k] = ta_reg[k-1];
            assign st_w[k]   = wa_reg[k-1];
            assign st_p[k]   = p_reg[k-1];
            assign st_q[k]   = q_reg[k-1];
        end

        // multiply beat
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tm_reg[k] <= '0;
            end
            else
            begin
                tm_reg[k] <= st_tag[k];
            end
        end

        always_ff @(posedge clk)
        begin
            wm_reg[k] <= st_w[k];
            mp_reg[k] <= PM_W'(st_w[k]) * PM_W'(atanpa_pkg::hmag(st_p[k]));
            mq_reg[k] <= PM_W'(st_w[k]) * PM_W'(atanpa_pkg::hmag(st_q[k]));
            np_reg[k] <= st_p[k][HW-1];
            nq_reg[k] <= st_q[k][HW-1];
        end

        // round half away from zero, then add the step coefficient
        assign rp = (mp_reg[k] + (PM_W'(1) << 29)) >> 30;
        assign rq = (mq_reg[k] + (PM_W'(1) << 29)) >> 30;
        assign sp = np_reg[k] ? -$signed(rp[HW-1:0]) : $signed(rp[HW-1:0]);
        assign sq = nq_reg[k] ? -$signed(rq[HW-1:0]) : $signed(rq[HW-1:0]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ta_reg[k] <= '0;
            end
            else
            begin
                ta_reg[k] <= tm_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            wa_reg[k] <= wm_reg[k];
            p_reg[k]  <= atanpa_pkg::p_addend(tm_reg[k].low_arg, k) + sp;
            q_reg[k]  <= atanpa_pkg::q_addend(tm_reg[k].low_arg, k) + sq;
        end
    end

    assign out_tag = ta_reg[NS-1];
    assign p       = p_reg[NS-1];
    assign q       = q_reg[NS-1];

endmodule

FILE: rtl/atanpa_ratio.sv
// ----------------------------------------------------------------------------
// atanpa_ratio
// Pipelined restoring divider for r = round(|p| * 2^30 / q) with sign of p.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atanpa_ratio
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  atanpa_pkg::tag_t                  in_tag,
    input  logic signed [atanpa_pkg::H_W-1:0] p,
    input  logic signed [atanpa_pkg::H_W-1:0] q,
    output atanpa_pkg::tag_t                  out_tag,
    output logic signed [atanpa_pkg::R_W-1:0] r
);

    localparam int HW  = atanpa_pkg::H_W;
    localparam int QN  = atanpa_pkg::QB;
    localparam int RW  = atanpa_pkg::R_W;
    localparam int D_W = HW + 30;

    atanpa_pkg::tag_t tag_reg [0:QN];
    logic [HW-1:0]    den_reg [0:QN];
    logic [HW-1:0]    rem_reg [0:QN];
    logic [QN-1:0]    low_reg [0:QN];
    logic [QN-1:0]    quo_reg [0:QN];
    logic             neg_reg [0:QN];

    logic [HW-1:0]    qf;
    logic [D_W-1:0]   dvd;

    always_comb
    begin
        qf  = (q <= 0) ? HW'(1) : HW'(q);
        dvd = {atanpa_pkg::hmag(p), 30'b0} + D_W'(qf >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= qf;
        rem_reg[0] <= HW'(dvd >> QN);
        low_reg[0] <= dvd[QN-1:0];
        quo_reg[0] <= '0;
        neg_reg[0] <= p[HW-1];
    end

    for (genvar i = 0; i < QN; i++)
    begin : g_stage
        localparam int B = QN - 1 - i;
        logic [HW:0] trial;
        logic        ge;

        assign trial = {rem_reg[i], low_reg[i][B]};
        assign ge    = (trial >= {1'b0, den_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i+1] <= '0;
            end
            else
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[i+1] <= den_reg[i];
            rem_reg[i+1] <= ge ? HW'(trial - {1'b0, den_reg[i]}) : HW'(trial);
            low_reg[i+1] <= low_reg[i];
            quo_reg[i+1] <= {quo_reg[i][QN-2:0], ge};
            neg_reg[i+1] <= neg_reg[i];
        end
    end

    assign out_tag = tag_reg[QN];
    assign r       = neg_reg[QN] ? -$signed(RW'(quo_reg[QN])) : $signed(RW'(quo_reg[QN]));

endmodule

FILE: rtl/arctan_pade_approximant.sv
// Throughput: one argument per cycle; busy is held low, start is always taken.
// Built from the two bit-serial divider pipelines (31 + 32 stages) and the
// five two-stage Horner steps.
// Reset: asynchronous, active low; clears every valid bit, no result follows.
// ----------------------------------------------------------------------------
// arctan_pade_approximant
// Order (11,10) Pade approximant of arctan, Q3.12 in, Q2.13 saturated out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arctan_pade_approximant_defines.svh"

module arctan_pade_approximant
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] x_value,
    output logic               done,
    output logic signed [15:0] atan_value
);

    localparam int UW  = atanpa_pkg::U_W;
    localparam int VW  = atanpa_pkg::V_W;
    localparam int HW  = atanpa_pkg::H_W;
    localparam int RW  = atanpa_pkg::R_W;
    localparam int FB  = atanpa_pkg::FRAC_BITS;
    localparam int PRW = 16 + RW;

    atanpa_pkg::tag_t     in_reg;
    logic [31:0]          sq;
    logic [UW-1:0]        u;

    atanpa_pkg::tag_t     rc_tag;
    logic [VW-1:0]        rc_w;
    atanpa_pkg::tag_t     hr_tag;
    logic signed [HW-1:0] hr_p;
    logic signed [HW-1:0] hr_q;
    atanpa_pkg::tag_t     ra_tag;
    logic signed [RW-1:0] ra_r;

    logic signed [RW-1:0] s;
    logic [RW-1:0]        s_mag;
    logic                 f1_valid_reg;
    logic [PRW-1:0]       f1_prod_reg;
    logic                 f1_neg_reg;
    logic [PRW-1:0]       rnd;
    logic [16:0]          clamp;
    logic signed [17:0]   res;
    logic signed [15:0]   sat_next;
    logic                 done_reg;
    logic signed [15:0]   atan_value_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else
        begin
            in_reg.valid   <= start && !busy;
            in_reg.low_arg <= 1'b0;
            in_reg.x       <= x_value;
        end
    end

    // u = x^2 rescaled to Q30
    assign sq = 32'(in_reg.x[15] ? -33'(in_reg.x) : 33'(in_reg.x))
              * 32'(in_reg.x[15] ? -33'(in_reg.x) : 33'(in_reg.x));

    if (atanpa_pkg::U_SHR == 0)
    begin : g_shl
        assign u = UW'(64'(sq) << atanpa_pkg::U_SHL);
    end
    else
    begin : g_shr
        assign u = UW'((64'(sq) + (64'd1 << (atanpa_pkg::U_SHR - 1))) >> atanpa_pkg::U_SHR);
    end

    atanpa_recip u_recip
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (in_reg),
        .u       (u),
        .out_tag (rc_tag),
        .w       (rc_w)
    );

    atanpa_horner u_horner
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (rc_tag),
        .w       (rc_w),
        .out_tag (hr_tag),
        .p       (hr_p),
        .q       (hr_q)
    );

    atanpa_ratio u_ratio
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (hr_tag),
        .p       (hr_p),
        .q       (hr_q),
        .out_tag (ra_tag),
        .r       (ra_r)
    );

    // s = 1 + p/q, then x * s back to Q2.13
    assign s     = RW'(atanpa_pkg::QONE) + ra_r;
    assign s_mag = s[RW-1] ? RW'(-s) : RW'(s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= ra_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_prod_reg <= PRW'(ra_tag.x[15] ? -17'(ra_tag.x) : 17'(ra_tag.x)) * PRW'(s_mag);
        f1_neg_reg  <= ra_tag.x[15] != s[RW-1];
    end

    always_comb
    begin
        rnd   = (f1_prod_reg + (PRW'(1) << (16 + FB))) >> (17 + FB);
        clamp = (rnd > PRW'(40000)) ? 17'd40000 : rnd[16:0];
        res   = f1_neg_reg ? -$signed({1'b0, clamp}) : $signed({1'b0, clamp});
        if (res > 18'sd32767)
            sat_next = 16'sh7fff;
        else if (res < -18'sd32768)
            sat_next = -16'sh8000;
        else
            sat_next = res[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        atan_value_reg <= sat_next;
    end

    assign done       = done_reg;
    assign atan_value = atan_value_reg;

    `ATANPA_ASSERT_DELAY(a_beat_arrives, clk, rst_n, start && !busy, atanpa_pkg::PIPE_LAT, done)
    `ATANPA_ASSERT_IMPLY(a_no_phantom, clk, rst_n, done, $past(start && !busy, atanpa_pkg::PIPE_LAT))
    `ATANPA_ASSERT_IMPLY(a_den_positive, clk, rst_n, hr_tag.valid, hr_q > 0)

endmodule

FILE: tb/atan_checker.sv
// ----------------------------------------------------------------------------
// atan_checker
// Watches argument and result beats of the arctan block, computes the
// expected Q2.13 value for each argument and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atan_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] x_value,
    input  logic               done,
    input  logic signed [15:0] atan_value,
    output int                 fail_count,
    output int                 pending
);

    localparam int FB = atanpa_pkg::FRAC_BITS;
    localparam longint ONE_Q30 = 64'sd1073741824;

    logic signed [15:0] atan_expected_q[$];

    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [15:0] atan_of(input logic signed [15:0] x);
        longint num [5];
        longint den [5];
        longint unsigned sq;
        longint unsigned u;
        longint unsigned m;
        longint p;
        longint q;
        longint v;
        longint s;
        longint res;
        longint xs;
        num = '{-64'sd357913941, -64'sd722645291, -64'sd479012643, -64'sd115271793,
                -64'sd7287006};
        den = '{64'sd2812180968, 64'sd2664171443, 64'sd1097011771, 64'sd182835295,
                64'sd8438552};
        xs = x;
        sq = ((xs < 0) ? -xs : xs) * ((xs < 0) ? -xs : xs);
        if (2 * FB <= 30)
            u = sq << (30 - 2 * FB);
        else
            u = (sq + (64'd1 << (2 * FB - 31))) >> (2 * FB - 30);
        if (u <= ONE_Q30) begin
            p = num[4];
            for (int i = 3; i >= 0; i--)
                p = num[i] + fx_mul(u, p);
            p = fx_mul(u, p);
            q = den[4];
            for (int i = 3; i >= 0; i--)
                q = den[i] + fx_mul(u, q);
            q = ONE_Q30 + fx_mul(u, q);
        end
        else begin
            v = ((64'd1 << 60) + (u >> 1)) / u;
            p = num[0];
            for (int i = 1; i < 5; i++)
                p = num[i] + fx_mul(v, p);
            q = ONE_Q30;
            for (int i = 0; i < 5; i++)
                q = den[i] + fx_mul(v, q);
        end
        if (q <= 0)
            q = 1;
        m = ((longint'((p < 0) ? -p : p) << 30) + (q >> 1)) / q;
        s = ONE_Q30 + ((p < 0) ? -longint'(m) : longint'(m));
        m = longint'((xs < 0) ? -xs : xs) * longint'((s < 0) ? -s : s);
        m = (m + (64'd1 << (16 + FB))) >> (17 + FB);
        if (m > 40000)
            m = 40000;
        res = ((xs < 0) != (s < 0)) ? -longint'(m) : longint'(m);
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return 16'(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
            atan_expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (atan_expected_q.size() == 0)
                begin
                    $error("unexpected result beat, atan_value=%0d", atan_value);
                    fail_count <= fail_count + 1;
                end
                else if (atan_value !== atan_expected_q[0])
                begin
                    $error("atan_value mismatch: expected %0d actual %0d",
                           atan_expected_q[0], atan_value);
                    fail_count <= fail_count + 1;
                    void'(atan_expected_q.pop_front());
                end
                else
                    void'(atan_expected_q.pop_front());
            end
            if (start && !busy)
                atan_expected_q.push_back(atan_of(x_value));
            pending <= atan_expected_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives arguments into the arctan block with random gaps and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] x_value;
    logic               done;
    logic signed [15:0] atan_value;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    arctan_pade_approximant dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .done       (done),
        .atan_value (atan_value)
    );

    atan_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .done       (done),
        .atan_value (atan_value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 90);
    endfunction

    task automatic send_arg(input logic signed [15:0] x, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        x_value <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [15:0] corner [$];
        logic signed [15:0] xr;
        int sel;
        start    = 1'b0;
        x_value  = '0;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, +-1.0 boundary of the small branch, extremes, alternating bits
        corner = '{16'sd0, 16'sd1, -16'sd1, 16'sd4095, 16'sd4096, 16'sd4097,
                   -16'sd4095, -16'sd4096, -16'sd4097, 16'sd32767, -16'sd32768,
                   -16'sd32767, 16'sd2048, -16'sd2048, 16'sd8192, -16'sd8192,
                   16'sh5555, 16'shAAAA, 16'sd100, -16'sd20000};
        foreach (corner[i])
            send_arg(corner[i], (i % 4 == 3) ? 2 : 0);

        for (int n = 0; n < 450; n++)
        begin
            sel = $urandom_range(0, 3);
            if (sel == 0)
                xr = 16'($urandom_range(0, 8191)) - 16'sd4096;
            else if (sel == 1)
                xr = 16'sd4096 + 16'($urandom_range(0, 16)) - 16'sd8;
            else
                xr = 16'($urandom);
            if (sel == 1 && $urandom_range(0, 1))
                xr = -xr;
            send_arg(xr, (n >= 150 && n < 220) ? 0 : gap_len());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
